[hw/rtl/htfd_pkg.sv]
`timescale 1ns / 1ps

package htfd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned RAW_W      = 20;
  localparam int unsigned HUM_CP_W   = 14;
  localparam int unsigned TEMP_CD_W  = 15;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned STORE_N    = 6;
  localparam int unsigned OUT_DATA_W = 88;

  // product widths: raw * scale
  localparam int unsigned HPROD_W = RAW_W + HUM_CP_W;      // 20 x 14
  localparam int unsigned TPROD_W = RAW_W + TEMP_CD_W;     // 20 x 15

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] BUSY_MASK = 8'h80;

  localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
  localparam logic [IDX_W-1:0] IDX_LAST_DATA = 3'd5;

  localparam logic [HUM_CP_W-1:0]  HUM_SCALE  = 14'd10000;
  localparam logic [TEMP_CD_W-1:0] TEMP_SCALE = 15'd20000;
  localparam logic [TEMP_CD_W-1:0] TEMP_OFFSET = 15'd5000;

  // -40 C and 85 C expressed on the unshifted product raw * 20000
  localparam logic [TPROD_W-1:0] TPROD_MIN = TPROD_W'(64'd1000 << 20);
  localparam logic [TPROD_W-1:0] TPROD_MAX = TPROD_W'(64'd13500 << 20);

  typedef logic [BYTE_W-1:0] byte_t;

  // one MSB-first CRC-8 update over a whole byte
  function automatic byte_t crc_feed(byte_t c, byte_t b);
    byte_t v;
    v = c ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

[hw/rtl/humidity_temp_frame_decoder.sv]
`timescale 1ns / 1ps

// Measurement reply decoder for a humidity / temperature sensor.
// Input channel (in_*): one reply byte per item, in_tuser marks the status
// byte that opens a frame. A frame is the status byte and five data bytes,
// plus a CRC-8 byte (poly 0x31, init 0xFF) when crc_enable is set. Bytes
// without a start mark continue the current frame; a new start mark drops a
// partial frame.
// Config channel (cfg_*): cfg_data[0] is crc_enable, always ready; write it
// only while no frame is in flight.
// Result channel (out_*): one item per completed frame with raw values,
// scaled values and status flags.
// Throughput: one byte per cycle while in_tready is high. The CRC update is one unrolled byte step.
// A finished frame passes through the frame capture register, then through
// the scaling multipliers into the output register.
// Reset clears the byte count, the CRC, crc_enable and both valid stages.
// When the receiver stalls, the output register holds its item and one more
// finished frame waits in the capture register; only then does in_tready
// drop, and only for bytes, since every byte updates the frame state.
module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // cfg_data: [0] crc_enable
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  // in_tdata: [7:0] rx_byte
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,
  // in_tuser: [0] frame_start
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: [7:0] status_byte, [27:8] humidity_raw, [47:28] temperature_raw,
  // [61:48] humidity_centipct, [76:62] temperature_centideg, [77] busy_res,
  // [78] crc_ok, [79] in_range, [80] result_ok, [87:81] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                 crc_enable_r;
  logic [IDX_W-1:0]     byte_index_r, byte_index_nxt;
  byte_t                crc_r, crc_nxt;
  byte_t                store_r [STORE_N];

  logic                 s1_v_r, s1_v_nxt;
  byte_t                s1_status_r;
  logic [RAW_W-1:0]     s1_hraw_r, s1_traw_r;
  logic                 s1_crc_good_r;

  logic                 out_v_r, out_v_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                 in_acc, s1_adv;
  logic [IDX_W-1:0]     idx;
  byte_t                crc_base, byte5;
  logic                 finish, crc_good, data_byte;

  logic [HPROD_W-1:0]   hprod;
  logic [TPROD_W-1:0]   tprod;
  logic [TEMP_CD_W-1:0] temp_cd;
  logic                 busy, inr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_enable_r <= 1'b0;
    end else if (cfg_valid) begin
      crc_enable_r <= cfg_data;
    end
  end

  // byte accept side
  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign idx       = in_tuser ? IDX_FIRST : byte_index_r;
  assign crc_base  = in_tuser ? CRC_INIT : crc_r;
  assign data_byte = (idx <= IDX_LAST_DATA);

  always_comb begin
    finish         = 1'b0;
    crc_good       = 1'b1;
    byte_index_nxt = byte_index_r;
    crc_nxt        = crc_r;
    if (in_acc) begin
      if (data_byte) begin
        crc_nxt = crc_feed(crc_base, in_tdata);
        if (idx == IDX_LAST_DATA && !crc_enable_r) begin
          finish = 1'b1;
        end else begin
          byte_index_nxt = idx + 1'b1;
        end
      end else begin
        // trailing CRC byte
        crc_good = crc_enable_r ? (crc_base == in_tdata) : 1'b1;
        finish   = 1'b1;
      end
      if (finish) begin
        byte_index_nxt = IDX_FIRST;
        crc_nxt        = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= IDX_FIRST;
      crc_r        <= CRC_INIT;
    end else begin
      byte_index_r <= byte_index_nxt;
      crc_r        <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && data_byte) begin
      store_r[idx] <= in_tdata;
    end
  end

  // byte 5 may be the byte that ends the frame this cycle
  assign byte5 = (idx == IDX_LAST_DATA) ? in_tdata : store_r[5];

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc && finish) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && finish) begin
      s1_status_r   <= store_r[0];
      s1_hraw_r     <= {store_r[1], store_r[2], store_r[3][7:4]};
      s1_traw_r     <= {store_r[3][3:0], store_r[4], byte5};
      s1_crc_good_r <= crc_good;
    end
  end

  // scaling stage
  assign hprod   = HPROD_W'(s1_hraw_r) * HPROD_W'(HUM_SCALE);
  assign tprod   = TPROD_W'(s1_traw_r) * TPROD_W'(TEMP_SCALE);
  assign temp_cd = tprod[TPROD_W-1:20] - TEMP_OFFSET;
  assign busy    = |(s1_status_r & BUSY_MASK);
  assign inr     = (tprod >= TPROD_MIN) && (tprod <= TPROD_MAX);

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_v_r && s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_adv) begin
      out_data_r <= {7'd0,
                     (!busy && s1_crc_good_r && inr),
                     inr,
                     s1_crc_good_r,
                     busy,
                     temp_cd,
                     hprod[HPROD_W-1:20],
                     s1_traw_r,
                     s1_hraw_r,
                     s1_status_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/htfd_checker.sv]
`timescale 1ns / 1ps

module htfd_checker
  import htfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic                 busy, crc_ok, inr, res_ok;
  logic signed [TEMP_CD_W-1:0] temp_cd;

  assign busy    = out_tdata[77];
  assign crc_ok  = out_tdata[78];
  assign inr     = out_tdata[79];
  assign res_ok  = out_tdata[80];
  assign temp_cd = out_tdata[76:62];

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_ok_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_ok == (!busy && crc_ok && inr))
    else $error("result_ok inconsistent with flags");

  // truncated temperature of an in-range result lies within -40.00..85.00
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && inr |-> temp_cd >= -15'sd4000 && temp_cd <= 15'sd8500)
    else $error("in_range set for out-of-range temperature");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import htfd_pkg::*;

  typedef struct {
    byte_t data;
    logic  start;
  } rx_item_t;

  typedef struct {
    byte_t                status;
    logic [RAW_W-1:0]     hum_raw;
    logic [RAW_W-1:0]     temp_raw;
    logic [HUM_CP_W-1:0]  hum_cp;
    logic [TEMP_CD_W-1:0] temp_cd;
    logic                 busy;
    logic                 crc_good;
    logic                 in_rng;
    logic                 all_ok;
  } reading_t;

  // raw temperature codes on either side of the -40 C and 85 C limits
  localparam logic [RAW_W-1:0] TRAW_BELOW_MIN = 20'd52428;
  localparam logic [RAW_W-1:0] TRAW_MIN       = 20'd52429;
  localparam logic [RAW_W-1:0] TRAW_MAX       = 20'd707788;
  localparam logic [RAW_W-1:0] TRAW_ABOVE_MAX = 20'd707789;
  localparam int unsigned      SETTLE_CYCLES  = 8;
  localparam int unsigned      PHASE_ITEMS    = 255;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;   // [7:0] rx_byte
  logic                  in_tuser = 1'b0; // [0] frame_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // status, raws, scaled values, flags

  humidity_temp_frame_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  rx_item_t    rx_items[$];
  reading_t    pending_readings[$];
  int unsigned made_items = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  // decoder mirror
  logic              crc_on = 1'b0;
  logic [IDX_W-1:0]  pos = IDX_FIRST;
  byte_t             crc_run = CRC_INIT;
  byte_t             frame_bytes [STORE_N];

  // stimulus side view of crc_enable
  logic        gen_crc = 1'b0;

  logic        byte_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  logic        in_steady = 1'b0;
  logic        out_steady = 1'b0;

  // bit-serial MSB-first CRC-8
  function automatic byte_t crc8_step(byte_t acc, byte_t b);
    byte_t r;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      r = (r[7] ^ b[k]) ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void decode_byte(byte_t b, logic start);
    logic             done;
    logic             good;
    logic [RAW_W-1:0] hr;
    logic [RAW_W-1:0] tr;
    logic [63:0]      hp;
    logic [63:0]      tp;
    reading_t         r;
    done = 1'b0;
    good = 1'b1;
    if (start) begin
      pos = IDX_FIRST;
      crc_run = CRC_INIT;
    end
    if (pos < STORE_N) begin
      frame_bytes[pos] = b;
      crc_run = crc8_step(crc_run, b);
      if (pos == IDX_LAST_DATA && !crc_on) begin
        done = 1'b1;
      end else begin
        pos = pos + 1'b1;
      end
    end else begin
      // index 6: CRC byte, always closes the frame
      good = crc_on ? (crc_run == b) : 1'b1;
      done = 1'b1;
    end
    if (done) begin
      pos = IDX_FIRST;
      crc_run = CRC_INIT;
      hr = {frame_bytes[1], frame_bytes[2], frame_bytes[3][7:4]};
      tr = {frame_bytes[3][3:0], frame_bytes[4], frame_bytes[5]};
      hp = 64'(hr) * 64'(HUM_SCALE);
      tp = 64'(tr) * 64'(TEMP_SCALE);
      r.status   = frame_bytes[0];
      r.hum_raw  = hr;
      r.temp_raw = tr;
      r.hum_cp   = HUM_CP_W'(hp >> 20);
      r.temp_cd  = TEMP_CD_W'((tp >> 20) - 64'(TEMP_OFFSET));
      // range test on the unshifted product, no truncation
      r.in_rng   = (tp >= (64'd1000 << 20)) && (tp <= (64'd13500 << 20));
      r.busy     = frame_bytes[0][7];
      r.crc_good = good;
      r.all_ok   = !r.busy && good && r.in_rng;
      pending_readings.push_back(r);
    end
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("mismatch in %s: got %0h, expected %0h (result %0d)",
             what, got, want, results_seen);
  endtask

  task automatic check_reading(logic [OUT_DATA_W-1:0] d);
    reading_t e;
    results_seen++;
    if (pending_readings.size() == 0) begin
      flag_mismatch("unexpected result, status", d[7:0], 0);
    end else begin
      e = pending_readings.pop_front();
      if (d[7:0] !== e.status)    flag_mismatch("status_byte", d[7:0], e.status);
      if (d[27:8] !== e.hum_raw)  flag_mismatch("humidity_raw", d[27:8], e.hum_raw);
      if (d[47:28] !== e.temp_raw) flag_mismatch("temperature_raw", d[47:28], e.temp_raw);
      if (d[61:48] !== e.hum_cp)  flag_mismatch("humidity_centipct", d[61:48], e.hum_cp);
      if (d[76:62] !== e.temp_cd) flag_mismatch("temperature_centideg", d[76:62], e.temp_cd);
      if (d[77] !== e.busy)       flag_mismatch("busy_res", d[77], e.busy);
      if (d[78] !== e.crc_good)   flag_mismatch("crc_ok", d[78], e.crc_good);
      if (d[79] !== e.in_rng)     flag_mismatch("in_range", d[79], e.in_rng);
      if (d[80] !== e.all_ok)     flag_mismatch("result_ok", d[80], e.all_ok);
      if (d[87:81] !== '0)        flag_mismatch("pad bits", d[87:81], 0);
    end
  endtask

  // input driver
  always @(negedge clk) begin
    rx_item_t item;
    if (rst_n && !(in_tvalid && !byte_taken)) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (rx_items.size() != 0) begin
        item = rx_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= item.data;
        in_tuser  <= item.start;
        if ($urandom_range(0, 47) == 0) in_steady = !in_steady;
        in_gap = in_steady ? 0 : $urandom_range(0, 3);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (out_hold != 0) begin
      out_tready <= 1'b0;
      out_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    byte_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        check_reading(out_tdata);
        if ($urandom_range(0, 47) == 0) out_steady = !out_steady;
        out_hold = out_steady ? 0 : $urandom_range(0, 3);
      end
    end
  end

  function automatic void push_item(byte_t d, logic s);
    rx_items.push_back(rx_item_t'{d, s});
    made_items++;
  endfunction

  function automatic void add_frame(byte_t st, logic [RAW_W-1:0] hr, logic [RAW_W-1:0] tr,
                                    logic mark, logic corrupt);
    byte_t b [STORE_N];
    byte_t c;
    b[0] = st;
    b[1] = hr[19:12];
    b[2] = hr[11:4];
    b[3] = {hr[3:0], tr[19:16]};
    b[4] = tr[15:8];
    b[5] = tr[7:0];
    c = CRC_INIT;
    for (int k = 0; k < STORE_N; k++) begin
      push_item(b[k], mark && k == 0);
      c = crc8_step(c, b[k]);
    end
    if (gen_crc) begin
      push_item(corrupt ? c ^ byte_t'($urandom_range(1, 255)) : c, 1'b0);
    end
  endfunction

  function automatic logic [RAW_W-1:0] pick_temp_raw();
    case ($urandom_range(0, 7))
      0: return TRAW_MIN + RAW_W'($urandom_range(0, 6)) - RAW_W'(3);
      1: return TRAW_MAX + RAW_W'($urandom_range(0, 6)) - RAW_W'(3);
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_hum_raw();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return RAW_W'($urandom);
  endfunction

  task automatic random_phase(int unsigned n_items);
    int unsigned stop;
    logic        synced;
    byte_t       st;
    stop = made_items + n_items;
    synced = 1'b1;
    while (made_items < stop) begin
      if ($urandom_range(0, 9) == 0) begin
        // broken frame: stray bytes with random start marks
        repeat ($urandom_range(1, gen_crc ? 6 : 5)) begin
          push_item(byte_t'($urandom), $urandom_range(0, 3) == 0);
        end
        synced = 1'b0;
      end else begin
        st = byte_t'($urandom);
        if ($urandom_range(0, 1)) st[7] = 1'b0;
        add_frame(st, pick_hum_raw(), pick_temp_raw(),
                  !synced || $urandom_range(0, 1), $urandom_range(0, 7) == 0);
        synced = 1'b1;
      end
    end
    // leave the decoder between frames
    add_frame(byte_t'($urandom), pick_hum_raw(), pick_temp_raw(), 1'b1, 1'b0);
  endtask

  task automatic settle();
    @(posedge clk);
    while (rx_items.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_crc_enable(logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    crc_on  = v;
    gen_crc = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic crc_plan [5];
    crc_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    for (int k = 0; k < STORE_N; k++) frame_bytes[k] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // CRC off after reset; first frame has no start mark
    add_frame(8'h00, '0, TRAW_BELOW_MIN, 1'b0, 1'b0);
    // partial frame dropped by a new start mark
    push_item(8'hA5, 1'b1);
    push_item(8'h5A, 1'b0);
    add_frame(8'h7F, '1, TRAW_MIN, 1'b1, 1'b0);
    settle();

    write_crc_enable(1'b1);
    add_frame(8'h80, 20'h80000, TRAW_MAX, 1'b1, 1'b0);
    add_frame(8'hFF, '0, TRAW_ABOVE_MAX, 1'b0, 1'b1);

    foreach (crc_plan[p]) begin
      settle();
      write_crc_enable(crc_plan[p]);
      random_phase(PHASE_ITEMS);
    end

    settle();
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/htfd_pkg.sv
hw/rtl/humidity_temp_frame_decoder.sv
hw/rtl/htfd_checker.sv
sim/testbench.sv
